// ===== sv/bpu_pkg.sv =====
// Types and constants shared by the bitmap pixel unpacker modules.
`timescale 1ns / 1ps
`default_nettype none
package bpu_pkg;

   localparam int unsigned OffsetWidth = 11;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned PosWidth    = 7;
   localparam int unsigned IdxWidth    = 4;
   localparam int unsigned ChanWidth   = 8;
   localparam int unsigned CntWidth    = 3;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrWidth    = 4;
   localparam int unsigned ReqWidth    = 24;
   localparam int unsigned RspWidth    = 40;

   localparam logic [PosWidth-1:0]  QuadShiftNorm = 7'd32;
   localparam logic [PosWidth-1:0]  QuadShiftHigh = 7'd64;
   localparam logic [ChanWidth-1:0] LevelLow      = 8'h80;
   localparam logic [ChanWidth-1:0] LevelFull     = 8'hff;
   localparam logic [IdxWidth-1:0]  GrayTop       = 4'hf;
   localparam logic [CntWidth-1:0]  LastNorm      = 3'd1;
   localparam logic [CntWidth-1:0]  LastHigh      = 3'd7;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_VIDEO_ON   = 3'd0,
      CSR_HIGH_RES   = 3'd1,
      CSR_TWO_K_MODE = 3'd2,
      CSR_COLOR_MODE = 3'd3,
      CSR_FG_COLOR   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic                video_on;
      logic                high_res;
      logic                two_k_mode;
      logic                color_mode;
      logic [IdxWidth-1:0] fg_color;
   } cfg_type;

   typedef struct packed {
      logic [PosWidth-1:0]  x_base;
      logic [PosWidth-1:0]  y_base;
      logic [ByteWidth-1:0] data;
      logic                 high_res;
   } item_type;

   typedef struct packed {
      logic [PosWidth-1:0] x_pos;
      logic [PosWidth-1:0] y_pos;
      logic [IdxWidth-1:0] idx;
      logic                lit;
      logic                last;
   } pix_type;

endpackage
`default_nettype wire

// ===== sv/bpu_decode.sv =====
// Input stage: splits the offset into quadrant, row and column and drops bytes out of range.
`timescale 1ns / 1ps
`default_nettype none
module bpu_decode
   import bpu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [OffsetWidth-1:0] byte_offset,
   input  wire logic [ByteWidth-1:0]   pixel_byte,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output item_type                    out_item
);

   logic          valid_ff, valid_in;
   item_type      item_ff, item_in;
   logic [1:0]    quad;
   logic [4:0]    row;
   logic [3:0]    col;
   logic [PosWidth-1:0] shift;
   logic          keep;

   always_comb begin
      quad  = byte_offset[10:9];
      row   = byte_offset[8:4];
      col   = byte_offset[3:0];
      shift = cfg.high_res ? QuadShiftHigh : QuadShiftNorm;
      keep  = cfg.two_k_mode || (quad == 2'd0);
      item_in.data     = pixel_byte;
      item_in.high_res = cfg.high_res;
      if (cfg.high_res) begin
         item_in.x_base = (quad[0] ? shift : 7'd0) + {1'b0, col, 2'b00};
         item_in.y_base = (quad[1] ? shift : 7'd0) + {1'b0, row, 1'b0};
      end else begin
         item_in.x_base = (quad[0] ? shift : 7'd0) + {2'b00, col, 1'b0};
         item_in.y_base = (quad[1] ? shift : 7'd0) + {2'b00, row};
      end
      in_ready = !valid_ff || out_ready;
      valid_in = in_valid && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== sv/bpu_serial.sv =====
// Serialiser: steps through the pixels of one byte and registers one pixel a cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module bpu_serial
   import bpu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [IdxWidth-1:0] fg_color,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire item_type            in_item,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output pix_type                  out_pix
);

   logic                item_valid_ff;
   item_type            item_ff;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                pix_valid_ff;
   pix_type             pix_ff, pix_in;
   logic                pix_take;
   logic                emit;

   always_comb begin
      pix_take = !pix_valid_ff || out_ready;
      emit     = item_valid_ff && pix_take;
      if (item_ff.high_res) begin
         pix_in.x_pos = item_ff.x_base + {5'b00000, cnt_ff[2], cnt_ff[0]};
         pix_in.y_pos = item_ff.y_base + {6'b000000, cnt_ff[1]};
         pix_in.idx   = fg_color;
         pix_in.lit   = item_ff.data[cnt_ff];
         pix_in.last  = (cnt_ff == LastHigh);
      end else begin
         pix_in.x_pos = item_ff.x_base + {6'b000000, cnt_ff[0]};
         pix_in.y_pos = item_ff.y_base;
         pix_in.idx   = cnt_ff[0] ? item_ff.data[7:4] : item_ff.data[3:0];
         pix_in.lit   = 1'b1;
         pix_in.last  = (cnt_ff == LastNorm);
      end
      in_ready = !item_valid_ff || (emit && pix_in.last);
      cnt_in   = in_ready ? '0 : (emit ? cnt_ff + 3'd1 : cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pix_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (in_ready) begin
            item_valid_ff <= in_valid;
         end
         if (pix_take) begin
            pix_valid_ff <= item_valid_ff;
         end
         cnt_ff <= cnt_in;
      end
      if (in_ready) begin
         item_ff <= in_item;
      end
      if (pix_take) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = pix_valid_ff;
   assign out_pix   = pix_ff;

endmodule
`default_nettype wire

// ===== sv/bpu_color.sv =====
// Output stage: palette lookup, blanking and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bpu_color
   import bpu_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire pix_type              in_pix,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RspWidth-1:0]       rsp_tdata,
   output logic                      rsp_tlast
);

   logic                 valid_ff;
   logic [RspWidth-1:0]  data_ff, data_in;
   logic                 last_ff;
   logic [ChanWidth-1:0] level;
   logic [ChanWidth-1:0] red, green, blue;
   logic [ChanWidth-1:0] gray;

   always_comb begin
      level = in_pix.idx[3] ? LevelFull : LevelLow;
      gray  = (in_pix.idx == GrayTop) ? LevelFull : {in_pix.idx, 4'b0000};
      if (!cfg.video_on || !in_pix.lit) begin
         red   = '0;
         green = '0;
         blue  = '0;
      end else if (cfg.color_mode) begin
         red   = in_pix.idx[0] ? level : '0;
         green = in_pix.idx[1] ? level : '0;
         blue  = in_pix.idx[2] ? level : '0;
      end else begin
         red   = gray;
         green = gray;
         blue  = gray;
      end
      data_in  = {2'b00, blue, green, red, in_pix.y_pos, in_pix.x_pos};
      in_ready = !valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
         last_ff <= in_pix.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ===== sv/bitmap_pixel_unpacker.sv =====
// Bitmap pixel unpacker top level: control registers and the pixel pipeline.
//
// req channel: one display-memory byte with its offset per transfer.
// rsp channel: one screen pixel per transfer; tlast marks the final pixel of a byte.
// csr port: csr_we writes csr_wdata into register csr_index at the clock edge;
//    indexes with no register are ignored. Write only while the block is idle.
// Pipeline: decode register, serialiser with its pixel register, colour register.
// Throughput: the serialiser emits one pixel a cycle unless the output stalls; a byte
//    gives two pixels in normal mode and eight in high resolution, and a byte beyond
//    the enabled size yields no pixel.
// Reset clears all control registers to zero (blanked, normal mode, 512 bytes, gray) and
//    empties the pipeline.
// Stall: when rsp_tready is low every full stage holds; req_tready falls once the
//    stages fill, and no pixel is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_pixel_unpacker
   import bpu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [ReqWidth-1:0]    req_tdata,  // byte_offset[10:0], pixel_byte[18:11]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RspWidth-1:0]         rsp_tdata,  // x_pos, y_pos, red, green, blue
   output logic                        rsp_tlast,
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrWidth-1:0]    csr_wdata
);

   cfg_type  cfg_ff;
   logic     dec_valid, dec_ready;
   item_type dec_item;
   logic     pix_valid, pix_ready;
   pix_type  pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VIDEO_ON:   cfg_ff.video_on   <= csr_wdata[0];
            CSR_HIGH_RES:   cfg_ff.high_res   <= csr_wdata[0];
            CSR_TWO_K_MODE: cfg_ff.two_k_mode <= csr_wdata[0];
            CSR_COLOR_MODE: cfg_ff.color_mode <= csr_wdata[0];
            CSR_FG_COLOR:   cfg_ff.fg_color   <= csr_wdata[IdxWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   bpu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .byte_offset (req_tdata[OffsetWidth-1:0]),
      .pixel_byte  (req_tdata[OffsetWidth+ByteWidth-1:OffsetWidth]),
      .out_valid   (dec_valid),
      .out_ready   (dec_ready),
      .out_item    (dec_item)
   );

   bpu_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .fg_color  (cfg_ff.fg_color),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_item   (dec_item),
      .out_valid (pix_valid),
      .out_ready (pix_ready),
      .out_pix   (pix)
   );

   bpu_color u_color (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (pix_valid),
      .in_ready   (pix_ready),
      .in_pix     (pix),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== verif/tb_bitmap_pixel_unpacker.sv =====
// Self-checking testbench for the bitmap pixel unpacker with its own pixel predictor.
`timescale 1ns / 1ps
module tb_bitmap_pixel_unpacker;
   import bpu_pkg::*;

   localparam int unsigned CycleLimit     = 400000;
   localparam int unsigned SettleCycles   = 16;
   localparam int unsigned LongHoldCycles = 300;
   localparam int unsigned BurstBytes     = 21;
   localparam logic [CsrIdxWidth-1:0] CsrSpareFirst = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrSpareLast  = 3'd7;

   typedef struct {
      logic [PosWidth-1:0]  x_pos;
      logic [PosWidth-1:0]  y_pos;
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic                 last_pixel;
   } screen_pixel_type;

   typedef struct {
      logic [OffsetWidth-1:0] offset;
      logic [ByteWidth-1:0]   data;
   } mem_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqWidth-1:0]    req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspWidth-1:0]    rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0]    csr_wdata = '0;

   cfg_type          shadow_cfg = '0;
   mem_byte_type     byte_queue[$];
   screen_pixel_type pending_pixels[$];

   int unsigned sender_idle_pct = 0;
   int unsigned rx_stall_pct    = 0;
   bit          sender_hold     = 1'b0;
   bit          hold_off_armed  = 1'b0;
   logic        rx_hold         = 1'b0;
   int unsigned bytes_queued    = 0;
   int unsigned bytes_accepted  = 0;
   int unsigned pixels_seen     = 0;
   int unsigned reg_writes      = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;

   bitmap_pixel_unpacker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [ChanWidth-1:0] got,
                                input logic [ChanWidth-1:0] want);
      if (got != want)
         report_mismatch($sformatf("pixel %0d %s got 0x%0h want 0x%0h",
                                   pixels_seen, name, got, want));
   endtask

   // Palette lookup; blanked video or a clear bit gives black.
   function automatic void shade(input logic [IdxWidth-1:0] idx, input logic lit,
                                 output logic [ChanWidth-1:0] r,
                                 output logic [ChanWidth-1:0] g,
                                 output logic [ChanWidth-1:0] b);
      logic [ChanWidth-1:0] level;
      r = '0;
      g = '0;
      b = '0;
      if (shadow_cfg.video_on && lit) begin
         if (shadow_cfg.color_mode) begin
            level = idx[3] ? LevelFull : LevelLow;
            r = idx[0] ? level : '0;
            g = idx[1] ? level : '0;
            b = idx[2] ? level : '0;
         end else begin
            level = (idx == GrayTop) ? LevelFull : {idx, 4'h0};
            r = level;
            g = level;
            b = level;
         end
      end
   endfunction

   function automatic void queue_pixel(input logic [PosWidth-1:0] x,
                                       input logic [PosWidth-1:0] y,
                                       input logic [IdxWidth-1:0] idx,
                                       input logic lit, input logic last);
      screen_pixel_type px;
      px.x_pos = x;
      px.y_pos = y;
      shade(idx, lit, px.red, px.green, px.blue);
      px.last_pixel = last;
      pending_pixels.push_back(px);
   endfunction

   // Work out the pixels painted by one accepted memory byte.
   function automatic void paint_byte(input logic [OffsetWidth-1:0] offset,
                                      input logic [ByteWidth-1:0] data);
      logic [1:0]          quad;
      logic [4:0]          row;
      logic [3:0]          col;
      logic [PosWidth-1:0] shift;
      logic [PosWidth-1:0] qx;
      logic [PosWidth-1:0] qy;
      logic [PosWidth-1:0] x;
      logic [PosWidth-1:0] y;
      logic [2:0]          b;
      quad = offset[10:9];
      row  = offset[8:4];
      col  = offset[3:0];
      if (!shadow_cfg.two_k_mode && quad != 2'd0)
         return;
      shift = shadow_cfg.high_res ? QuadShiftHigh : QuadShiftNorm;
      qx = quad[0] ? shift : '0;
      qy = quad[1] ? shift : '0;
      if (!shadow_cfg.high_res) begin
         x = qx + {2'b00, col, 1'b0};
         y = qy + {2'b00, row};
         queue_pixel(x, y, data[3:0], 1'b1, 1'b0);
         queue_pixel(x + 7'd1, y, data[7:4], 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < 8; i++) begin
            b = i[2:0];
            x = qx + {1'b0, col, 2'b00} + {5'b00000, b[2], b[0]};
            y = qy + {1'b0, row, 1'b0} + {6'b000000, b[1]};
            queue_pixel(x, y, shadow_cfg.fg_color, data[i], b == 3'd7);
         end
      end
   endfunction

   // Offer queued bytes; keep the current one until its transfer completes.
   always @(posedge clock) begin : req_driver
      mem_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            paint_byte(req_tdata[10:0], req_tdata[18:11]);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() != 0 && !sender_hold &&
                $urandom_range(99) >= sender_idle_pct) begin
               nxt = byte_queue.pop_front();
               req_tdata  <= {5'b0, nxt.data, nxt.offset};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      screen_pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                         rsp_tdata[6:0], rsp_tdata[13:7]));
            end else begin
               want = pending_pixels.pop_front();
               compare_field("x_pos", {1'b0, rsp_tdata[6:0]}, {1'b0, want.x_pos});
               compare_field("y_pos", {1'b0, rsp_tdata[13:7]}, {1'b0, want.y_pos});
               compare_field("red", rsp_tdata[21:14], want.red);
               compare_field("green", rsp_tdata[29:22], want.green);
               compare_field("blue", rsp_tdata[37:30], want.blue);
               compare_field("last_pixel", {7'b0000000, rsp_tlast},
                             {7'b0000000, want.last_pixel});
            end
            pixels_seen++;
         end
         rsp_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin : rx_long_hold
      wait (hold_off_armed);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (LongHoldCycles) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("bitmap_pixel_unpacker verification failed");
         $finish;
      end
   end

   task automatic queue_byte(input logic [OffsetWidth-1:0] offset,
                             input logic [ByteWidth-1:0] data);
      mem_byte_type item;
      item.offset = offset;
      item.data   = data;
      byte_queue.push_back(item);
      bytes_queued++;
   endtask

   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrWidth-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_VIDEO_ON:   shadow_cfg.video_on   = value[0];
         CSR_HIGH_RES:   shadow_cfg.high_res   = value[0];
         CSR_TWO_K_MODE: shadow_cfg.two_k_mode = value[0];
         CSR_COLOR_MODE: shadow_cfg.color_mode = value[0];
         CSR_FG_COLOR:   shadow_cfg.fg_color   = value;
         default: ;
      endcase
   endtask

   // Single-bit registers get random upper bits, which must be dropped.
   task automatic write_flag(input logic [CsrIdxWidth-1:0] idx, input logic value);
      write_reg(idx, {3'($urandom_range(7)), value});
   endtask

   task automatic random_setup(input int hres, input int twok);
      logic [IdxWidth-1:0] fg;
      case ($urandom_range(3))
         0:       fg = 4'h0;
         1:       fg = 4'hf;
         default: fg = 4'($urandom_range(15));
      endcase
      write_flag(CSR_VIDEO_ON, $urandom_range(99) < 88);
      write_flag(CSR_HIGH_RES, (hres < 0) ? 1'($urandom_range(1)) : 1'(hres));
      write_flag(CSR_TWO_K_MODE, (twok < 0) ? 1'($urandom_range(1)) : 1'(twok));
      write_flag(CSR_COLOR_MODE, 1'($urandom_range(1)));
      write_reg(CSR_FG_COLOR, fg);
      if ($urandom_range(3) == 0)
         write_reg(3'($urandom_range(CsrSpareLast, CsrSpareFirst)),
                   4'($urandom_range(15)));
   endtask

   // Queue random bytes until the given number land inside the enabled size.
   task automatic random_burst(input int unsigned painting_bytes);
      int unsigned            painted;
      logic [OffsetWidth-1:0] off;
      logic [ByteWidth-1:0]   data;
      painted = 0;
      while (painted < painting_bytes) begin
         if (!shadow_cfg.two_k_mode && $urandom_range(99) < 85)
            off = 11'($urandom_range(511));
         else
            off = 11'($urandom_range(2047));
         case ($urandom_range(9))
            0:       data = 8'h00;
            1:       data = 8'hff;
            default: data = 8'($urandom_range(255));
         endcase
         queue_byte(off, data);
         if (shadow_cfg.two_k_mode || off < 11'd512)
            painted++;
      end
   endtask

   initial begin : stimulus
      int unsigned offs[8];
      offs = '{0, 15, 496, 527, 1040, 1551, 2032, 2047};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: blanked, normal, 512 bytes, gray.
      queue_byte(11'd0, 8'hff);
      queue_byte(11'd511, 8'h5a);
      queue_byte(11'd512, 8'h3c);
      queue_byte(11'd2047, 8'hc3);
      wait_idle();

      // Every nibble value in every quadrant, gray then colour.
      write_flag(CSR_VIDEO_ON, 1'b1);
      write_flag(CSR_TWO_K_MODE, 1'b1);
      for (int p = 0; p < 2; p++) begin
         write_flag(CSR_COLOR_MODE, p[0]);
         for (int i = 0; i < 8; i++)
            queue_byte(11'(offs[i]), {4'(2 * i + 1), 4'(2 * i)});
         wait_idle();
      end

      // High resolution with the foreground extremes and a write to an unused index.
      write_flag(CSR_HIGH_RES, 1'b1);
      write_reg(CSR_FG_COLOR, 4'hf);
      queue_byte(11'd0, 8'hff);
      queue_byte(11'd2047, 8'h5a);
      wait_idle();
      write_reg(CSR_FG_COLOR, 4'h8);
      write_reg(CsrSpareFirst, 4'hf);
      queue_byte(11'd1536, 8'hff);
      wait_idle();
      write_flag(CSR_COLOR_MODE, 1'b0);
      write_flag(CSR_TWO_K_MODE, 1'b0);
      write_reg(CSR_FG_COLOR, 4'h0);
      queue_byte(11'd511, 8'ha5);
      queue_byte(11'd1024, 8'hff);
      wait_idle();
      write_reg(CSR_FG_COLOR, 4'hf);
      queue_byte(11'd300, 8'h96);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin sender_idle_pct = 74; rx_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rx_stall_pct = 74; end
            default: begin sender_idle_pct = 25; rx_stall_pct = 25; end
         endcase
         for (int chunk = 0; chunk < 4; chunk++) begin
            if (phase == 0 && chunk == 1) begin
               // Hold the receiver off while the sender keeps offering.
               random_setup(1, 1);
               hold_off_armed = 1'b1;
               random_burst(BurstBytes);
            end else if (phase == 3 && chunk == 2) begin
               // Pause the sender mid-burst until every pixel is out.
               random_setup(-1, -1);
               random_burst(BurstBytes);
               while (bytes_accepted + BurstBytes / 2 < bytes_queued)
                  @(posedge clock);
               sender_hold = 1'b1;
               while (bytes_accepted + byte_queue.size() != bytes_queued ||
                      pending_pixels.size() != 0)
                  @(posedge clock);
               sender_hold = 1'b0;
            end else begin
               random_setup(-1, -1);
               random_burst(BurstBytes);
            end
            wait_idle();
         end
      end

      if (pending_pixels.size() != 0)
         report_mismatch($sformatf("%0d expected pixels never arrived",
                                   pending_pixels.size()));
      $display("Run covered %0d memory bytes and %0d pixel transfers over %0d register writes,",
               bytes_accepted, pixels_seen, reg_writes);
      $display("both resolutions, both sizes, both palettes, blanking and stalls on both sides.");
      if (mismatch_count == 0)
         $display("bitmap_pixel_unpacker verification clean");
      else
         $display("bitmap_pixel_unpacker verification failed");
      $finish;
   end

endmodule
